// ===== design/sit_pkg.sv =====
// Shared widths, codes and stage-advance type for the segment intersection test.
`timescale 1ns / 1ps

package sit_pkg;

  // Coordinate width and the widths that grow from it.
  localparam int COORD_BITS = 24;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int CROSS_W    = PROD_W + 1;

  // Configuration register widths.
  localparam int EPS_COORD_W = 24;
  localparam int EPS_AREA_W  = 48;

  // Compare widths wide enough for both a magnitude and its tolerance.
  localparam int COORD_CMP_W = (DIFF_W > EPS_COORD_W) ? DIFF_W : EPS_COORD_W;
  localparam int AREA_CMP_W  = (CROSS_W > EPS_AREA_W) ? CROSS_W : EPS_AREA_W;

  // Register port: 64-bit words at byte addresses 0 and 8.
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 64;
  localparam int REG_SEL_BIT = 3;

  typedef enum logic {
    REG_EPS_COORD = 1'b0,
    REG_EPS_AREA  = 1'b1
  } sit_reg_e;

  typedef enum logic [2:0] {
    OUT_DISJOINT  = 3'd0,
    OUT_COLLINEAR = 3'd1,
    OUT_SHARED    = 3'd2,
    OUT_NOCROSS   = 3'd3,
    OUT_CROSS     = 3'd4
  } sit_outcome_e;

  // Load enables for the three stages inside a cross-product unit.
  typedef struct packed {
    logic mul;
    logic sub;
    logic sgn;
  } sit_adv_t;

endpackage

// ===== design/segment_intersection_test.sv =====
// Top level of the pipelined 2D segment intersection test.
`timescale 1ns / 1ps
//
// Usage
//   Input channel (in_valid_i / in_ready_o) carries one word: the two endpoints
//   of segment A and of segment B as signed coordinates. Output channel
//   (out_valid_o / out_ready_i) returns one word per input word: hit_o and the
//   outcome code (boxes disjoint, collinear, shared endpoint, no crossing,
//   crossing). Words leave in the order they arrived.
// Stages and throughput
//   Five register stages: differences, products plus box and endpoint tests,
//   cross-product subtract, tolerance compare, classification. One word per
//   cycle is sustained while out_ready_i stays high; each of the four cross
//   products owns two 25x25 multipliers.
// Stalls
//   Each stage advances when it is empty or the stage after it advances, so
//   bubbles are squeezed out and in_ready_o stays high while any stage is free.
//   A held output word keeps its value until taken.
// Reset
//   rst_ni clears every stage valid bit and sets both tolerances to 1.
//   Tolerances are written over the APB-style port (eps_coord at 0, eps_area at
//   8); the user writes them only while the pipeline is empty, unchecked by the block.

module segment_intersection_test (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [sit_pkg::PADDR_W-1:0]           paddr,
  input  logic [sit_pkg::PDATA_W-1:0]           pwdata,
  output logic [sit_pkg::PDATA_W-1:0]           prdata,
  output logic                                  pready,
  // input channel
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [sit_pkg::COORD_BITS-1:0] a_start_x_i,
  input  logic signed [sit_pkg::COORD_BITS-1:0] a_start_y_i,
  input  logic signed [sit_pkg::COORD_BITS-1:0] a_end_x_i,
  input  logic signed [sit_pkg::COORD_BITS-1:0] a_end_y_i,
  input  logic signed [sit_pkg::COORD_BITS-1:0] b_start_x_i,
  input  logic signed [sit_pkg::COORD_BITS-1:0] b_start_y_i,
  input  logic signed [sit_pkg::COORD_BITS-1:0] b_end_x_i,
  input  logic signed [sit_pkg::COORD_BITS-1:0] b_end_y_i,
  // output channel
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  hit_o,
  output logic [2:0]                            outcome_o
);
  import sit_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [EPS_COORD_W-1:0] eps_coord_q, eps_coord_d;
  logic [EPS_AREA_W-1:0]  eps_area_q, eps_area_d;
  logic                   cfg_wr;
  sit_reg_e               reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = sit_reg_e'(paddr[REG_SEL_BIT]);

  always_comb begin
    eps_coord_d = eps_coord_q;
    eps_area_d  = eps_area_q;
    prdata      = '0;
    unique case (reg_sel)
      REG_EPS_COORD: begin
        prdata = PDATA_W'(eps_coord_q);
        if (cfg_wr) begin
          eps_coord_d = pwdata[EPS_COORD_W-1:0];
        end
      end
      REG_EPS_AREA: begin
        prdata = PDATA_W'(eps_area_q);
        if (cfg_wr) begin
          eps_area_d = pwdata[EPS_AREA_W-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_coord_q <= EPS_COORD_W'(1);
      eps_area_q  <= EPS_AREA_W'(1);
    end else begin
      eps_coord_q <= eps_coord_d;
      eps_area_q  <= eps_area_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage control: advance a stage when it is empty or its successor advances
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, vo_q;
  logic en1, en2, en3, en4, en_o;
  sit_adv_t adv;

  assign en_o = !vo_q || out_ready_i;
  assign en4  = !v4_q || en_o;
  assign en3  = !v3_q || en4;
  assign en2  = !v2_q || en3;
  assign en1  = !v1_q || en2;

  assign in_ready_o = en1;
  assign adv        = '{mul: en2, sub: en3, sgn: en4};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en_o) vo_q <= v4_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: coordinate differences
  // Pair order for the endpoint differences: A1-B1, A1-B2, A2-B1, A2-B2.
  // ---------------------------------------------------------------------------
  logic signed [DIFF_W-1:0] dpx_q [4];
  logic signed [DIFF_W-1:0] dpy_q [4];
  logic signed [DIFF_W-1:0] dax_q, day_q, dbx_q, dby_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      dpx_q[0] <= DIFF_W'(a_start_x_i) - DIFF_W'(b_start_x_i);
      dpy_q[0] <= DIFF_W'(a_start_y_i) - DIFF_W'(b_start_y_i);
      dpx_q[1] <= DIFF_W'(a_start_x_i) - DIFF_W'(b_end_x_i);
      dpy_q[1] <= DIFF_W'(a_start_y_i) - DIFF_W'(b_end_y_i);
      dpx_q[2] <= DIFF_W'(a_end_x_i) - DIFF_W'(b_start_x_i);
      dpy_q[2] <= DIFF_W'(a_end_y_i) - DIFF_W'(b_start_y_i);
      dpx_q[3] <= DIFF_W'(a_end_x_i) - DIFF_W'(b_end_x_i);
      dpy_q[3] <= DIFF_W'(a_end_y_i) - DIFF_W'(b_end_y_i);
      dax_q    <= DIFF_W'(a_end_x_i) - DIFF_W'(a_start_x_i);
      day_q    <= DIFF_W'(a_end_y_i) - DIFF_W'(a_start_y_i);
      dbx_q    <= DIFF_W'(b_end_x_i) - DIFF_W'(b_start_x_i);
      dby_q    <= DIFF_W'(b_end_y_i) - DIFF_W'(b_start_y_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: bounding-box reject and endpoint match, beside the multipliers
  // The boxes are apart on an axis when every A end lies strictly on one side of
  // every B end, i.e. all four differences share a strict sign.
  // ---------------------------------------------------------------------------
  logic [3:0]        x_pos, x_neg, y_pos, y_neg, pt_match;
  logic [DIFF_W-1:0] mag_x [4];
  logic [DIFF_W-1:0] mag_y [4];
  logic              disj_d, shared_d;
  logic              disj2_q, shared2_q, disj3_q, shared3_q, disj4_q, shared4_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      x_neg[i] = dpx_q[i][DIFF_W-1];
      y_neg[i] = dpy_q[i][DIFF_W-1];
      x_pos[i] = !dpx_q[i][DIFF_W-1] && (dpx_q[i] != '0);
      y_pos[i] = !dpy_q[i][DIFF_W-1] && (dpy_q[i] != '0);
      mag_x[i] = dpx_q[i][DIFF_W-1] ? DIFF_W'($unsigned(-dpx_q[i]))
                                    : DIFF_W'($unsigned(dpx_q[i]));
      mag_y[i] = dpy_q[i][DIFF_W-1] ? DIFF_W'($unsigned(-dpy_q[i]))
                                    : DIFF_W'($unsigned(dpy_q[i]));
      pt_match[i] = (COORD_CMP_W'(mag_x[i]) < COORD_CMP_W'(eps_coord_q)) &&
                    (COORD_CMP_W'(mag_y[i]) < COORD_CMP_W'(eps_coord_q));
    end
    disj_d   = (&x_pos) || (&x_neg) || (&y_pos) || (&y_neg);
    shared_d = |pt_match;
  end

  // carry the flags alongside the cross-product stages
  always_ff @(posedge clk_i) begin
    if (en2) begin
      disj2_q   <= disj_d;
      shared2_q <= shared_d;
    end
    if (en3) begin
      disj3_q   <= disj2_q;
      shared3_q <= shared2_q;
    end
    if (en4) begin
      disj4_q   <= disj3_q;
      shared4_q <= shared3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 2-4: four orientation cross products
  // Against A, use (A1-B) rather than (B-A1): both signs flip together, so the
  // zero tests and the sign-product rule are unchanged.
  //   unit 0: B1 against A   unit 1: B2 against A
  //   unit 2: A1 against B   unit 3: A2 against B
  // ---------------------------------------------------------------------------
  logic [3:0] zero4, neg4;

  sit_cross u_cross_b1 (
    .clk_i      (clk_i),
    .adv_i      (adv),
    .px_i       (dpx_q[0]),
    .py_i       (dpy_q[0]),
    .dx_i       (dax_q),
    .dy_i       (day_q),
    .eps_area_i (eps_area_q),
    .zero_o     (zero4[0]),
    .neg_o      (neg4[0])
  );

  sit_cross u_cross_b2 (
    .clk_i      (clk_i),
    .adv_i      (adv),
    .px_i       (dpx_q[1]),
    .py_i       (dpy_q[1]),
    .dx_i       (dax_q),
    .dy_i       (day_q),
    .eps_area_i (eps_area_q),
    .zero_o     (zero4[1]),
    .neg_o      (neg4[1])
  );

  sit_cross u_cross_a1 (
    .clk_i      (clk_i),
    .adv_i      (adv),
    .px_i       (dpx_q[0]),
    .py_i       (dpy_q[0]),
    .dx_i       (dbx_q),
    .dy_i       (dby_q),
    .eps_area_i (eps_area_q),
    .zero_o     (zero4[2]),
    .neg_o      (neg4[2])
  );

  sit_cross u_cross_a2 (
    .clk_i      (clk_i),
    .adv_i      (adv),
    .px_i       (dpx_q[2]),
    .py_i       (dpy_q[2]),
    .dx_i       (dbx_q),
    .dy_i       (dby_q),
    .eps_area_i (eps_area_q),
    .zero_o     (zero4[3]),
    .neg_o      (neg4[3])
  );

  // ---------------------------------------------------------------------------
  // Stage 5: classification into the output register
  // Priority: disjoint boxes, collinear, shared endpoint, then the sign rule
  // (each pair has a zero or opposite signs).
  // ---------------------------------------------------------------------------
  sit_outcome_e outcome_d, outcome_q;
  logic         straddle_a, straddle_b;
  logic         hit_q;

  always_comb begin
    straddle_a = zero4[0] || zero4[1] || (neg4[0] != neg4[1]);
    straddle_b = zero4[2] || zero4[3] || (neg4[2] != neg4[3]);
    if (disj4_q) begin
      outcome_d = OUT_DISJOINT;
    end else if (zero4[0] && zero4[1]) begin
      outcome_d = OUT_COLLINEAR;
    end else if (shared4_q) begin
      outcome_d = OUT_SHARED;
    end else if (straddle_a && straddle_b) begin
      outcome_d = OUT_CROSS;
    end else begin
      outcome_d = OUT_NOCROSS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      outcome_q <= outcome_d;
      hit_q     <= (outcome_d == OUT_CROSS);
    end
  end

  assign out_valid_o = vo_q;
  assign hit_o       = hit_q;
  assign outcome_o   = outcome_q;

`ifndef SYNTHESIS
  // hit agrees with the outcome code
  a_hit_matches_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hit_o == (outcome_o == OUT_CROSS)))
    else $error("hit_o disagrees with outcome_o");

  // a taken output frees every stage, so input must be ready
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled although output is being taken");

  // an empty output register never blocks the input
  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output register");

  // a word enters the first stage only through an accepted handshake
  a_stage1_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(v1_q) |-> $past(in_valid_i && in_ready_o))
    else $error("first stage became valid without an accepted word");
`endif

endmodule

// ===== design/sit_cross.sv =====
// Three-stage cross product with near-zero suppression and sign extraction.
`timescale 1ns / 1ps

module sit_cross (
  input  logic                                   clk_i,
  input  sit_pkg::sit_adv_t                      adv_i,
  input  logic signed [sit_pkg::DIFF_W-1:0]      px_i,
  input  logic signed [sit_pkg::DIFF_W-1:0]      py_i,
  input  logic signed [sit_pkg::DIFF_W-1:0]      dx_i,
  input  logic signed [sit_pkg::DIFF_W-1:0]      dy_i,
  input  logic        [sit_pkg::EPS_AREA_W-1:0]  eps_area_i,
  output logic                                   zero_o,
  output logic                                   neg_o
);
  import sit_pkg::*;

  logic signed [PROD_W-1:0]  pxdy_q, pydx_q;
  logic signed [CROSS_W-1:0] cross_d, cross_q;
  logic        [CROSS_W-1:0] mag;
  logic                      zero_d, neg_d;
  logic                      zero_q, neg_q;

  // px*dy - py*dx, one multiplier each in the first stage
  always_ff @(posedge clk_i) begin
    if (adv_i.mul) begin
      pxdy_q <= px_i * dy_i;
      pydx_q <= py_i * dx_i;
    end
  end

  assign cross_d = CROSS_W'(pxdy_q) - CROSS_W'(pydx_q);

  always_ff @(posedge clk_i) begin
    if (adv_i.sub) begin
      cross_q <= cross_d;
    end
  end

  // drop values whose magnitude is under the area tolerance
  always_comb begin
    mag    = cross_q[CROSS_W-1] ? CROSS_W'($unsigned(-cross_q)) : CROSS_W'($unsigned(cross_q));
    zero_d = (AREA_CMP_W'(mag) < AREA_CMP_W'(eps_area_i)) || (cross_q == '0);
    neg_d  = cross_q[CROSS_W-1] && !zero_d;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.sgn) begin
      zero_q <= zero_d;
      neg_q  <= neg_d;
    end
  end

  assign zero_o = zero_q;
  assign neg_o  = neg_q;

endmodule
